[src/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table depth, derived index/count widths, field widths, request and
// status codes, and the stored record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

	// table size and derived widths
	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths of the request and response words
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned EXT_W    = 12;
	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned POS_W    = 10;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned STATUS_W = 3;

	// request types
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

	// one stored table entry
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [EXT_W-1:0]  ext;
		logic [SIZE_W-1:0] size;
	} rec_t;

endpackage

`default_nettype wire

[src/skt_if.sv]
// ----------------------------------------------------------------------------
// skt_if: request and response channels of the sorted key table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_req_if;
	import skt_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [KEY_W-1:0]  new_key;
	logic [EXT_W-1:0]  new_ext;
	logic [SIZE_W-1:0] new_size;
	logic [POS_W-1:0]  read_index;

	modport source (
		output valid, req_type, new_key, new_ext, new_size, read_index,
		input  ready
	);

	modport sink (
		input  valid, req_type, new_key, new_ext, new_size, read_index,
		output ready
	);
endinterface

interface skt_rsp_if;
	import skt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [COUNT_W-1:0]  entry_count;
	logic [KEY_W-1:0]    entry_key;
	logic [EXT_W-1:0]    entry_ext;
	logic [SIZE_W-1:0]   entry_size;

	modport source (
		output valid, status, position, entry_count, entry_key, entry_ext, entry_size,
		input  ready
	);

	modport sink (
		input  valid, status, position, entry_count, entry_key, entry_ext, entry_size,
		output ready
	);
endinterface

`default_nettype wire

[src/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram: simple dual-port RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 60,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/sorted_key_table_insert.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_insert: sorted record table with binary-search insert
//
// Holds up to TABLE_DEPTH records (32-bit key, 12-bit extension, 16-bit
// size) in ascending key order in one dual-port RAM. Request words arrive on
// the req channel, one response word per request leaves on rsp.
// An insert binary-searches the table: each probe is one RAM read (S_SEARCH)
// plus one key compare (S_CMP), with at most log2(count)+1 probes. A new key
// then shifts the entries above the insertion point up one place, one entry
// per cycle over the RAM's read and write ports, and S_INS then writes the
// new record. A duplicate key, key zero (the reserved root) or a full table
// ends the request without a write. An in-range read passes S_RD_WAIT, where
// the record is captured, before S_RESP; an out-of-range read goes straight
// to S_RESP, which loads the output register and raises rsp.valid.
// The shift length (count minus insertion point) dominates an insert's time.
// One request is in flight at a time: req.ready is high only while the
// sequencer is idle. The response sits in an output register; a stalled
// receiver does not stop the next request from being accepted, but that
// request's response waits until the register is free.
// Reset clears the record count and the sequencer; the RAM is not cleared,
// and only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_insert (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skt_req_if.sink    req,
	skt_rsp_if.source  rsp
);
	import skt_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RD_WAIT = 3'd1;
	localparam logic [2:0] S_SEARCH  = 3'd2;
	localparam logic [2:0] S_CMP     = 3'd3;
	localparam logic [2:0] S_SHIFT   = 3'd4;
	localparam logic [2:0] S_INS     = 3'd5;
	localparam logic [2:0] S_RESP    = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_pend_q;
	logic             rsp_valid_q;

	// request latch and search window
	logic [KEY_W-1:0]  key_q;
	logic [EXT_W-1:0]  ext_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  mid_q;
	logic [CNT_W-1:0]  i_q;
	logic [IDX_W-1:0]  wr_addr_q;

	// pending result
	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0]    res_pos_q;
	rec_t                res_rec_q;

	// output register
	logic [STATUS_W-1:0] out_status_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [COUNT_W-1:0]  out_count_q;
	rec_t                out_rec_q;

	// RAM ports
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	rec_t             mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [$bits(rec_t)-1:0] mem_rdata;
	rec_t             rd_rec;

	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] shift_src;
	logic             in_range;
	logic             tbl_full;
	logic             out_free;
	logic             key_lt;
	logic             key_gt;

	skt_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH ($bits(rec_t))
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// shared compare and index arithmetic
	assign rd_rec    = rec_t'(mem_rdata);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign shift_src = i_q - CNT_W'(1);
	assign in_range  = 32'(req.read_index) < 32'(count_q);
	assign tbl_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign key_lt    = key_q < rd_rec.key;
	assign key_gt    = key_q > rd_rec.key;

	assign req.ready = (state_q == S_IDLE);

	// RAM read address
	always_comb begin
		unique case (state_q)
			S_IDLE:   mem_raddr = IDX_W'(req.read_index);
			S_SEARCH: mem_raddr = mid[IDX_W-1:0];
			S_SHIFT:  mem_raddr = shift_src[IDX_W-1:0];
			default:  mem_raddr = '0;
		endcase
	end

	// RAM write: shift moves, then the new record
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = rd_rec;
		unique case (state_q)
			S_SHIFT: begin
				mem_we = wr_pend_q;
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[IDX_W-1:0];
				mem_wdata = '{key: key_q, ext: ext_q, size: size_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer and record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			wr_pend_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.req_type == REQ_READ) begin
							state_q <= in_range ? S_RD_WAIT : S_RESP;
						end else begin
							state_q <= (req.new_key == '0) ? S_RESP : S_SEARCH;
						end
					end
				end
				S_RD_WAIT: begin
					state_q <= S_RESP;
				end
				S_SEARCH: begin
					wr_pend_q <= 1'b0;
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else if (tbl_full) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_CMP: begin
					state_q <= (!key_lt && !key_gt) ? S_RESP : S_SEARCH;
				end
				S_SHIFT: begin
					wr_pend_q <= (i_q > lo_q);
					if (!(i_q > lo_q)) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response valid: set on load of the output register, held until handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= ((state_q == S_RESP) && out_free) || (rsp_valid_q && !rsp.ready);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					key_q     <= req.new_key;
					ext_q     <= req.new_ext;
					size_q    <= req.new_size;
					lo_q      <= '0;
					hi_q      <= count_q;
					res_rec_q <= '0;
					if (req.req_type == REQ_READ) begin
						res_status_q <= in_range ? ST_READ : ST_RANGE;
						res_pos_q    <= req.read_index;
					end else begin
						res_status_q <= ST_DUPLICATE;
						res_pos_q    <= '0;
					end
				end
			end
			S_RD_WAIT: begin
				res_rec_q <= rd_rec;
			end
			S_SEARCH: begin
				mid_q <= mid;
				if (!(lo_q < hi_q)) begin
					if (tbl_full) begin
						res_status_q <= ST_FULL;
						res_pos_q    <= '0;
					end else begin
						i_q <= count_q;
					end
				end
			end
			S_CMP: begin
				if (key_lt) begin
					hi_q <= mid_q;
				end else if (key_gt) begin
					lo_q <= mid_q + CNT_W'(1);
				end else begin
					res_status_q <= ST_DUPLICATE;
					res_pos_q    <= POS_W'(mid_q);
				end
			end
			S_SHIFT: begin
				if (i_q > lo_q) begin
					wr_addr_q <= i_q[IDX_W-1:0];
					i_q       <= shift_src;
				end
			end
			S_INS: begin
				res_status_q <= ST_INSERTED;
				res_pos_q    <= POS_W'(lo_q);
			end
			S_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_pos_q    <= res_pos_q;
					out_count_q  <= COUNT_W'(count_q);
					out_rec_q    <= res_rec_q;
				end
			end
			default: begin
			end
		endcase
	end

	// response channel
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.position    = out_pos_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.entry_key   = out_rec_q.key;
	assign rsp.entry_ext   = out_rec_q.ext;
	assign rsp.entry_size  = out_rec_q.size;

	// count never passes the table depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("record count above table depth");

	// count only grows, by one, after the record write
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CNT_W'(1)) && ($past(state_q) == S_INS))
		else $error("record count changed outside an insert");

	// no table write while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("table written while idle");

	// every probe lies inside the live part of the table
	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> (lo_q < hi_q) && (hi_q <= count_q) && (mid_q < hi_q))
		else $error("search probe outside the table");

	// a response only appears from the response state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_RESP)
		else $error("response raised outside the response state");

endmodule

`default_nettype wire
